FILE: sv/pir_occupancy_idle_controller_assert.svh
// assertion macros for the occupancy idle controller checker
`ifndef PIR_OCCUPANCY_IDLE_CONTROLLER_ASSERT_SVH
`define PIR_OCCUPANCY_IDLE_CONTROLLER_ASSERT_SVH

// same-cycle implication under reset
`define PIOC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("pioc assertion failed");

// next-cycle implication under reset
`define PIOC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("pioc assertion failed");

`endif

FILE: sv/pioc_pkg.sv
// types and constants shared by the occupancy idle controller files
package pioc_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CHECK_W  = 16;
	localparam int unsigned IDLE_W   = 20;
	localparam int unsigned RETX_W   = 16;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned CFG_W    = 20;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned IN_W     = 40;
	localparam int unsigned OUT_W    = 8;

	localparam logic [CHECK_W-1:0] CHECK_RST = 16'd60;
	localparam logic [IDLE_W-1:0]  IDLE_RST  = 20'd600;
	localparam logic [RETX_W-1:0]  RETX_RST  = 16'd120;
	localparam logic [THR_W-1:0]   THR_RST   = 8'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef enum logic [IDX_W-1:0] {
		REG_CHECK_INTERVAL = 2'd0,
		REG_MAX_IDLE       = 2'd1,
		REG_RETX_INTERVAL  = 2'd2,
		REG_OCC_THRESHOLD  = 2'd3
	} reg_idx_t;

	// result bits, highest first
	typedef struct packed {
		logic send_ir;
		logic ac_off;
		logic room_occupied;
		logic check_done;
		logic motion_level;
		logic motion_event;
	} result_t;

	// bit positions of the result fields in the output tdata
	localparam int unsigned OB_EVENT = 0;
	localparam int unsigned OB_LEVEL = 1;
	localparam int unsigned OB_DONE  = 2;
	localparam int unsigned OB_OCC   = 3;
	localparam int unsigned OB_ACOFF = 4;
	localparam int unsigned OB_SEND  = 5;

endpackage

FILE: sv/pir_occupancy_idle_controller.sv
// occupancy idle controller: motion start counting, periodic check, ac-off and ir send
//
// Usage:
//   s_axis carries one sensor sample per transfer: sensor_a, sensor_b and a 32-bit
//   seconds timestamp. m_axis returns exactly one result per sample: motion event,
//   combined level, check flag, occupancy result, held ac-off flag and ir send pulse.
//   Each sample is evaluated against the internal state in the cycle it is accepted
//   and its result sits in the output register from the next cycle. Throughput is
//   one sample per cycle while the receiver takes results; the only loop is the
//   state update done in the accepting cycle, three 32-bit subtract-and-compare
//   operations. When the receiver stalls, the result register holds and
//   s_axis_tready drops until the result is taken; a new sample is taken in the
//   same cycle the held result leaves.
//   Reset loads the register defaults (60, 600, 120, 1) and clears all timestamps,
//   the start count, the previous level and the ac-off flag, so time counts from reset.
//   Registers are written via cfg_we/cfg_index/cfg_wdata, by the user only while idle
//   (the block does not enforce it); values are truncated to each register's width.
module pir_occupancy_idle_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pioc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pioc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// sensor_a[0], sensor_b[1], now_sec[33:2], zero pad[39:34]
	input  logic [pioc_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// motion_event[0], motion_level[1], check_done[2], room_occupied[3],
	// ac_off[4], send_ir[5], zero pad[7:6]
	output logic [pioc_pkg::OUT_W-1:0]   m_axis_tdata
);

	logic [pioc_pkg::CHECK_W-1:0] check_interval_q;
	logic [pioc_pkg::IDLE_W-1:0]  max_idle_q;
	logic [pioc_pkg::RETX_W-1:0]  retx_interval_q;
	logic [pioc_pkg::THR_W-1:0]   occ_threshold_q;

	logic                          prev_level_q;
	logic [pioc_pkg::COUNT_W-1:0]  start_count_q;
	logic [pioc_pkg::TIME_W-1:0]   last_check_q;
	logic [pioc_pkg::TIME_W-1:0]   last_occ_q;
	logic [pioc_pkg::TIME_W-1:0]   last_send_q;
	logic                          ac_off_q;

	logic                          out_valid_q;
	pioc_pkg::result_t             out_res_q;

	logic                          accept;
	logic                          level;
	logic [pioc_pkg::TIME_W-1:0]   now;
	logic [pioc_pkg::COUNT_W-1:0]  count_inc;
	logic [pioc_pkg::TIME_W-1:0]   since_check;
	logic [pioc_pkg::TIME_W-1:0]   since_occ;
	logic [pioc_pkg::TIME_W-1:0]   since_send;
	logic                          check_due;
	logic                          occ;
	logic                          idle_over;
	logic                          ac_off_nxt;
	logic                          send;
	pioc_pkg::result_t             res;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign level = s_axis_tdata[0] | s_axis_tdata[1];
	assign now   = s_axis_tdata[33:2];

	always_comb begin
		count_inc = start_count_q;
		if (level && !prev_level_q && (start_count_q != pioc_pkg::COUNT_MAX)) begin
			count_inc = start_count_q + 8'd1;
		end
		since_check = now - last_check_q;
		since_occ   = now - last_occ_q;
		since_send  = now - last_send_q;
		check_due   = since_check > {16'd0, check_interval_q};
		occ         = check_due && (count_inc > occ_threshold_q);
		// a fresh occupied check restarts idle time at zero, so the flag drops
		idle_over   = !occ && (since_occ > {12'd0, max_idle_q});
		ac_off_nxt  = check_due ? idle_over : ac_off_q;
		send        = check_due && idle_over && (since_send > {16'd0, retx_interval_q});

		res.motion_event  = level ^ prev_level_q;
		res.motion_level  = level;
		res.check_done    = check_due;
		res.room_occupied = occ;
		res.ac_off        = ac_off_nxt;
		res.send_ir       = send;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_interval_q <= pioc_pkg::CHECK_RST;
			max_idle_q       <= pioc_pkg::IDLE_RST;
			retx_interval_q  <= pioc_pkg::RETX_RST;
			occ_threshold_q  <= pioc_pkg::THR_RST;
		end else if (cfg_we) begin
			case (pioc_pkg::reg_idx_t'(cfg_index))
				pioc_pkg::REG_CHECK_INTERVAL: check_interval_q <= cfg_wdata[15:0];
				pioc_pkg::REG_MAX_IDLE:       max_idle_q       <= cfg_wdata;
				pioc_pkg::REG_RETX_INTERVAL:  retx_interval_q  <= cfg_wdata[15:0];
				pioc_pkg::REG_OCC_THRESHOLD:  occ_threshold_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= 1'b0;
			start_count_q <= '0;
			last_check_q  <= '0;
			last_occ_q    <= '0;
			last_send_q   <= '0;
			ac_off_q      <= 1'b0;
		end else if (accept) begin
			prev_level_q <= level;
			ac_off_q     <= ac_off_nxt;
			if (check_due) begin
				start_count_q <= '0;
				last_check_q  <= now;
			end else begin
				start_count_q <= count_inc;
			end
			if (occ) begin
				last_occ_q <= now;
			end
			if (send) begin
				last_send_q <= now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_res_q};

endmodule

FILE: sv/pioc_checker.sv
// port-level checker for the occupancy idle controller, bound to the top level
`include "pir_occupancy_idle_controller_assert.svh"

module pioc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [pioc_pkg::OUT_W-1:0]   m_axis_tdata
);

	logic out_send;
	logic out_acoff;
	logic out_occ;
	logic out_done;

	assign out_send  = m_axis_tdata[pioc_pkg::OB_SEND];
	assign out_acoff = m_axis_tdata[pioc_pkg::OB_ACOFF];
	assign out_occ   = m_axis_tdata[pioc_pkg::OB_OCC];
	assign out_done  = m_axis_tdata[pioc_pkg::OB_DONE];

	// an ir send only goes out while ac-off is raised
	`PIOC_ASSERT_NOW(a_send_needs_acoff, clk, arst_n, m_axis_tvalid && out_send, out_acoff)
	// occupancy result only comes with a check
	`PIOC_ASSERT_NOW(a_occ_needs_check, clk, arst_n, m_axis_tvalid && out_occ, out_done)
	// an occupied check resets the idle time, so ac-off cannot be raised with it
	`PIOC_ASSERT_NOW(a_occ_clears_acoff, clk, arst_n, m_axis_tvalid && out_occ, !out_acoff)
	// a stalled result holds
	`PIOC_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind pir_occupancy_idle_controller pioc_checker u_pioc_checker (.*);
